[src/tdq_pkg.sv]
// ---------------------------------------------------------------------------
// tdq_pkg: shared types and constants for the timer deadline queue
// Slot count, field widths, opcodes, status codes and sequencer states.
// ---------------------------------------------------------------------------
package tdq_pkg;

    localparam int CAPACITY    = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int ID_W   = 16;
    localparam int TIME_W = 63;
    localparam int IV_W   = 32;
    localparam int OP_W   = 2;
    localparam int STS_W  = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // stream word widths, rounded up to whole bytes
    localparam int IN_FIELDS_W   = ID_W + TIME_W + IV_W + TIME_W;
    localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = ID_W + 1 + 1 + TIME_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2
    } opcode_t;

    // spare opcode: accepted and dropped
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_FULL      = 3'd1,
        STS_DUP       = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_EXPIRED   = 3'd4,
        STS_NONE      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_SEL,
        ST_TAKE,
        ST_MIN,
        ST_EMIT
    } state_t;

endpackage

[src/timer_deadline_queue.sv]
// ---------------------------------------------------------------------------
// timer_deadline_queue: table of armed timers with ordered expiry reporting
// Holds up to CAPACITY timers and walks the slot table with one shared
// compare unit under a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one command word per handshake. s_tuser is the opcode
//   (add, cancel, tick); s_tdata carries id, deadline, interval and now.
//   m_ channel: result words. m_tuser is the status, m_tlast marks the final
//   word of a command, which alone carries next_valid and next_deadline.
//   Add and cancel give one word; tick gives one word per expired timer
//   (up to MAX_RESULTS, in deadline then id order) or one "nothing expired".
//   Opcode 3 is accepted and dropped without a result.
// Sequence of a command, from the take:
//   add/cancel: info scan over all slots, update, minimum scan, load of the
//   word; the next command is taken once the sequencer is back in idle.
//   tick: rounds of a selection scan and a take step, one round per expired
//   timer plus a last round that finds none, unless MAX_RESULTS timers were
//   found, then the minimum scan, then the words at one per cycle while the
//   m_ side does not stall.
//   Each scan reads one slot at a time through the single slot-read port.
// s_tready is high only while idle. The result register is separate, so a
// new command is taken while the last word of the previous one still waits;
// a stalled m_ side holds the word and the sequencer waits before loading.
// Reset (aresetn low, synchronous) empties the table and drops any word.
// ---------------------------------------------------------------------------
module timer_deadline_queue
    import tdq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // lowest bit up: timer_id[15:0], deadline[78:16], interval[110:79],
    // now[173:111], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // lowest bit up: expired_id[15:0], earliest_changed[16], next_valid[17],
    // next_deadline[80:18], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [STS_W-1:0]      m_tuser,
    output logic                  m_tlast
);

    // control state
    state_t             state_reg, state_next;
    opcode_t            op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CAPACITY-1:0] slot_valid_reg;
    logic [CAPACITY-1:0] taken_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               min_any_reg;
    logic               best_any_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [RES_W-1:0]   k_reg;
    status_t            status_reg;
    logic               changed_reg;
    logic               out_valid_reg;

    // payload
    logic [ID_W-1:0]    slot_id_reg       [CAPACITY];
    logic [TIME_W-1:0]  slot_deadline_reg [CAPACITY];
    logic [IV_W-1:0]    slot_interval_reg [CAPACITY];
    logic [ID_W-1:0]    ids_reg           [MAX_RESULTS];
    logic [ID_W-1:0]    id_reg;
    logic [TIME_W-1:0]  dl_reg;
    logic [IV_W-1:0]    iv_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  min_dl_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [TIME_W-1:0]  best_dl_reg;
    logic [ID_W-1:0]    best_id_reg;
    logic [IV_W-1:0]    best_iv_reg;
    status_t            out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic               out_changed_reg;
    logic               out_nv_reg;
    logic [TIME_W-1:0]  out_nd_reg;
    logic               out_last_reg;

    // shared scan unit
    logic               sv;
    logic [ID_W-1:0]    sid;
    logic [TIME_W-1:0]  sdl;
    logic               idx_last;
    logic               min_upd;
    logic               cand;
    logic               better;
    logic [TIME_W:0]    rearm_sum;
    logic [TIME_W-1:0]  rearm_dl;

    // outputs of the sequencer
    logic               in_take;
    logic               load_out;
    logic               res_last;
    status_t            res_status;
    logic [ID_W-1:0]    res_id;
    logic               res_changed;
    logic               res_nv;
    logic [TIME_W-1:0]  res_nd;

    assign sv       = slot_valid_reg[idx_reg];
    assign sid      = slot_id_reg[idx_reg];
    assign sdl      = slot_deadline_reg[idx_reg];
    assign idx_last = (idx_reg == IDX_W'(CAPACITY - 1));
    assign min_upd  = sv && (!min_any_reg || (sdl < min_dl_reg));
    assign cand     = sv && !taken_reg[idx_reg] && (sdl <= now_reg);
    assign better   = !best_any_reg || (sdl < best_dl_reg) ||
                      ((sdl == best_dl_reg) && (sid < best_id_reg));

    assign rearm_sum = {1'b0, now_reg} + {{(TIME_W + 1 - IV_W){1'b0}}, best_iv_reg};
    assign rearm_dl  = rearm_sum[TIME_W] ? TIME_MAX : rearm_sum[TIME_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    unique case (s_tuser)
                        OP_ADD, OP_CANCEL: state_next = ST_SCAN;
                        OP_TICK:           state_next = ST_SEL;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:  if (idx_last) state_next = ST_APPLY;
            ST_APPLY: state_next = ST_MIN;
            ST_SEL:   if (idx_last) state_next = ST_TAKE;
            ST_TAKE: begin
                if (best_any_reg && (n_reg != CNT_W'(MAX_RESULTS - 1)))
                    state_next = ST_SEL;
                else
                    state_next = ST_MIN;
            end
            ST_MIN:   if (idx_last) state_next = ST_EMIT;
            ST_EMIT:  if (load_out && res_last) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and result word
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        in_take  = s_tvalid && s_tready;
        load_out = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
        res_last = (op_reg != OP_TICK) || (n_reg == '0) ||
                   ({1'b0, k_reg} == n_reg - CNT_W'(1));
        if (op_reg == OP_TICK) begin
            res_status = (n_reg == '0) ? STS_NONE : STS_EXPIRED;
            res_id     = (n_reg == '0) ? '0 : ids_reg[k_reg];
        end else begin
            res_status = status_reg;
            res_id     = '0;
        end
        res_changed = (op_reg == OP_TICK) ? 1'b0 : changed_reg;
        res_nv      = res_last && min_any_reg;
        res_nd      = res_nv ? min_dl_reg : '0;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_ADD;
            idx_reg        <= '0;
            slot_valid_reg <= '0;
            taken_reg      <= '0;
            found_reg      <= 1'b0;
            found_idx_reg  <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            min_any_reg    <= 1'b0;
            best_any_reg   <= 1'b0;
            n_reg          <= '0;
            k_reg          <= '0;
            status_reg     <= STS_OK;
            changed_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= load_out || (out_valid_reg && !m_tready);

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_take) begin
                        op_reg       <= opcode_t'(s_tuser);
                        idx_reg      <= '0;
                        found_reg    <= 1'b0;
                        free_reg     <= 1'b0;
                        min_any_reg  <= 1'b0;
                        best_any_reg <= 1'b0;
                        taken_reg    <= '0;
                        n_reg        <= '0;
                        k_reg        <= '0;
                        changed_reg  <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (sv && (sid == id_reg) && !found_reg) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= idx_reg;
                    end
                    if (!sv && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if (min_upd) min_any_reg <= 1'b1;
                end
                ST_APPLY: begin
                    idx_reg     <= '0;
                    min_any_reg <= 1'b0;
                    if (op_reg == OP_ADD) begin
                        if (found_reg) begin
                            status_reg <= STS_DUP;
                        end else if (!free_reg) begin
                            status_reg <= STS_FULL;
                        end else begin
                            status_reg  <= STS_OK;
                            changed_reg <= !min_any_reg || (dl_reg < min_dl_reg);
                            slot_valid_reg[free_idx_reg] <= 1'b1;
                        end
                    end else begin
                        if (found_reg) begin
                            status_reg <= STS_OK;
                            slot_valid_reg[found_idx_reg] <= 1'b0;
                        end else begin
                            status_reg <= STS_NOT_FOUND;
                        end
                    end
                end
                ST_SEL: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (cand && better) best_any_reg <= 1'b1;
                end
                ST_TAKE: begin
                    idx_reg      <= '0;
                    best_any_reg <= 1'b0;
                    min_any_reg  <= 1'b0;
                    if (best_any_reg) begin
                        taken_reg[best_idx_reg] <= 1'b1;
                        n_reg <= n_reg + CNT_W'(1);
                        // one-shot timers leave the table
                        if (best_iv_reg == '0) slot_valid_reg[best_idx_reg] <= 1'b0;
                    end
                end
                ST_MIN: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (min_upd) min_any_reg <= 1'b1;
                end
                ST_EMIT: begin
                    if (load_out && !res_last) k_reg <= k_reg + RES_W'(1);
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            id_reg  <= s_tdata[ID_W-1:0];
            dl_reg  <= s_tdata[ID_W +: TIME_W];
            iv_reg  <= s_tdata[ID_W+TIME_W +: IV_W];
            now_reg <= s_tdata[ID_W+TIME_W+IV_W +: TIME_W];
        end
        if (((state_reg == ST_SCAN) || (state_reg == ST_MIN)) && min_upd)
            min_dl_reg <= sdl;
        if ((state_reg == ST_SEL) && cand && better) begin
            best_idx_reg <= idx_reg;
            best_dl_reg  <= sdl;
            best_id_reg  <= sid;
            best_iv_reg  <= slot_interval_reg[idx_reg];
        end
        if ((state_reg == ST_APPLY) && (op_reg == OP_ADD) && !found_reg && free_reg) begin
            slot_id_reg[free_idx_reg]       <= id_reg;
            slot_deadline_reg[free_idx_reg] <= dl_reg;
            slot_interval_reg[free_idx_reg] <= iv_reg;
        end
        if ((state_reg == ST_TAKE) && best_any_reg) begin
            ids_reg[n_reg[RES_W-1:0]] <= best_id_reg;
            if (best_iv_reg != '0) slot_deadline_reg[best_idx_reg] <= rearm_dl;
        end
        if (load_out) begin
            out_status_reg  <= res_status;
            out_id_reg      <= res_id;
            out_changed_reg <= res_changed;
            out_nv_reg      <= res_nv;
            out_nd_reg      <= res_nd;
            out_last_reg    <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, out_nd_reg, out_nv_reg,
                       out_changed_reg, out_id_reg};

    // non-final words are always expiry reports
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser == STS_EXPIRED))
        else $error("non-final word without expired status");

    // each selection round has marked exactly the timers reported so far
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL) |-> ($countones(taken_reg) == int'(n_reg)))
        else $error("taken mask out of step with expiry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CNT_W'(MAX_RESULTS))
        else $error("expiry count beyond limit");

    // a real command keeps the input closed while it is worked on
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser != OP_UNUSED)) |=> !s_tready)
        else $error("input reopened during command");

endmodule

[test/timer_deadline_queue_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// timer_deadline_queue_test: self-checking bench for the timer deadline queue
// Drives add, cancel and tick commands, keeps its own copy of the timer
// table to predict every result word, and checks each word in order.
// ---------------------------------------------------------------------------
module timer_deadline_queue_test;
    import tdq_pkg::*;

    localparam int RUN_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 600;
    localparam int ID_POOL       = 23;

    typedef struct {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic              changed;
        logic              nv;
        logic [TIME_W-1:0] nd;
        logic              last;
    } timer_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // lowest bit up: timer_id, deadline, interval, now, zero pad
    logic [IN_DATA_W-1:0]  s_tdata;
    // opcode
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // lowest bit up: expired_id, earliest_changed, next_valid, next_deadline, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    // status
    logic [STS_W-1:0]      m_tuser;
    logic                  m_tlast;

    // predicted timer table
    logic              armed      [CAPACITY];
    logic [ID_W-1:0]   arm_id     [CAPACITY];
    logic [TIME_W-1:0] arm_due    [CAPACITY];
    logic [IV_W-1:0]   arm_period [CAPACITY];

    timer_word_t       words_due [$];
    int                errors        = 0;
    int                cycle_count   = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_left     = 0;
    logic [TIME_W-1:0] wall_now      = '0;

    timer_deadline_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: long hold-off first, else random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic soonest(output logic [TIME_W-1:0] due);
        logic any;
        any = 1'b0;
        due = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (armed[i] && (!any || arm_due[i] < due)) begin
                due = arm_due[i];
                any = 1'b1;
            end
        end
        return any;
    endfunction

    function automatic int find_timer(input logic [ID_W-1:0] id);
        for (int i = 0; i < CAPACITY; i++)
            if (armed[i] && arm_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void push_word(input status_t st, input logic [ID_W-1:0] id,
                                      input logic changed, input logic nv,
                                      input logic [TIME_W-1:0] nd, input logic last);
        timer_word_t w;
        w.status  = st;
        w.id      = id;
        w.changed = changed;
        w.nv      = nv;
        w.nd      = nd;
        w.last    = last;
        words_due.insert(words_due.size(), w);
    endfunction

    function automatic void apply_command(input logic [OP_W-1:0] op,
                                          input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] dl,
                                          input logic [IV_W-1:0] iv,
                                          input logic [TIME_W-1:0] now);
        int                slot;
        int                best;
        logic              nv;
        logic              changed;
        logic [TIME_W-1:0] nd;
        logic [TIME_W-1:0] cur;
        logic [TIME_W:0]   sum;
        status_t           st;
        logic              taken [CAPACITY];
        int                order [$];
        logic [ID_W-1:0]   fired [$];

        unique case (op)
            OP_ADD: begin
                st      = STS_OK;
                changed = 1'b0;
                if (find_timer(id) >= 0) begin
                    st = STS_DUP;
                end else begin
                    slot = -1;
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (!armed[i])
                            slot = i;
                    if (slot < 0) begin
                        st = STS_FULL;
                    end else begin
                        if (!soonest(cur))
                            changed = 1'b1;
                        else
                            changed = (dl < cur);
                        armed[slot]      = 1'b1;
                        arm_id[slot]     = id;
                        arm_due[slot]    = dl;
                        arm_period[slot] = iv;
                    end
                end
                nv = soonest(nd);
                push_word(st, '0, changed, nv, nd, 1'b1);
            end
            OP_CANCEL: begin
                slot = find_timer(id);
                st   = STS_NOT_FOUND;
                if (slot >= 0) begin
                    armed[slot] = 1'b0;
                    st          = STS_OK;
                end
                nv = soonest(nd);
                push_word(st, '0, 1'b0, nv, nd, 1'b1);
            end
            OP_TICK: begin
                foreach (taken[i])
                    taken[i] = 1'b0;
                // pick due timers by deadline, then id
                repeat (MAX_RESULTS) begin
                    best = -1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (armed[i] && !taken[i] && arm_due[i] <= now &&
                            (best < 0 || arm_due[i] < arm_due[best] ||
                             (arm_due[i] == arm_due[best] && arm_id[i] < arm_id[best])))
                            best = i;
                    end
                    if (best < 0)
                        break;
                    taken[best] = 1'b1;
                    order.insert(order.size(), best);
                end
                foreach (order[k]) begin
                    slot = order[k];
                    fired.insert(fired.size(), arm_id[slot]);
                    if (arm_period[slot] != 0) begin
                        // re-arm, saturate at the top of the time range
                        sum = {1'b0, now} + arm_period[slot];
                        arm_due[slot] = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
                    end else begin
                        armed[slot] = 1'b0;
                    end
                end
                nv = soonest(nd);
                if (fired.size() == 0) begin
                    push_word(STS_NONE, '0, 1'b0, nv, nd, 1'b1);
                end else begin
                    foreach (fired[k]) begin
                        if (k == fired.size() - 1)
                            push_word(STS_EXPIRED, fired[k], 1'b0, nv, nd, 1'b1);
                        else
                            push_word(STS_EXPIRED, fired[k], 1'b0, 1'b0, '0, 1'b0);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors = errors + 1;
        end
    endtask

    always @(posedge aclk) begin : check_words
        timer_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (words_due.size() == 0) begin
                $error("result word with nothing pending, status %0d", m_tuser);
                errors = errors + 1;
            end else begin
                want = words_due.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("expired_id", want.id, m_tdata[15:0]);
                check_field("earliest_changed", want.changed, m_tdata[16]);
                check_field("next_valid", want.nv, m_tdata[17]);
                check_field("next_deadline", want.nd, m_tdata[80:18]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] ahead(input logic [TIME_W-1:0] base,
                                                input int unsigned span);
        logic [TIME_W:0] s;
        s = {1'b0, base} + span;
        return (s > TIME_MAX) ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] dl, input logic [IV_W-1:0] iv,
                            input logic [TIME_W-1:0] now);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, now, iv, dl, id};
        do @(posedge aclk); while (!s_tready);
        apply_command(op, id, dl, iv, now);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (words_due.size() != 0)
            @(posedge aclk);
    endtask

    // one command of mixed traffic; returns 0 for a dropped opcode
    task automatic send_random_cmd(output bit counted);
        int unsigned       pick;
        int unsigned       r;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dl;
        logic [TIME_W-1:0] now;
        logic [IV_W-1:0]   iv;

        pick    = $urandom_range(99);
        counted = 1'b1;
        id = ($urandom_range(9) == 0) ? ID_W'($urandom_range(65535))
                                      : ID_W'($urandom_range(ID_POOL));
        dl  = rand_time();
        now = rand_time();
        iv  = $urandom;
        if (pick < 45) begin
            r = $urandom_range(19);
            if (r == 1)
                dl = (wall_now > 100) ? wall_now - 100 : '0;
            else if (r != 0)
                dl = ahead(wall_now, 10 * $urandom_range(150));
            r = $urandom_range(9);
            if (r < 4)
                iv = '0;
            else if (r < 8)
                iv = $urandom_range(1, 400);
            else if (r == 9)
                iv = '1;
            send_cmd(OP_ADD, id, dl, iv, now);
        end else if (pick < 63) begin
            send_cmd(OP_CANCEL, id, dl, iv, now);
        end else if (pick < 95) begin
            r = $urandom_range(39);
            if (r == 1) begin
                now      = TIME_MAX - $urandom_range(3000);
                wall_now = now;
            end else if (r == 2) begin
                // restart the clock low; late timers stay armed
                wall_now = $urandom_range(5000);
                now      = wall_now;
            end else if (r > 2) begin
                now      = ahead(wall_now, $urandom_range(700));
                wall_now = now;
            end
            send_cmd(OP_TICK, id, dl, iv, now);
        end else begin
            send_cmd(OP_UNUSED, ID_W'($urandom), dl, iv, now);
            counted = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_basic_ops();
        send_cmd(OP_CANCEL, 16'h0000, '0, '0, '0);
        send_cmd(OP_TICK, '0, '0, '0, '0);
        send_cmd(OP_ADD, 16'h0000, TIME_MAX, '0, '0);
        send_cmd(OP_ADD, 16'hFFFF, '0, '1, '0);
        send_cmd(OP_ADD, 16'h0000, 63'd5, '0, '0);
        // equal deadline must not move the earliest mark
        send_cmd(OP_ADD, 16'd5, '0, '0, '0);
        send_cmd(OP_UNUSED, '1, TIME_MAX, '1, TIME_MAX);
        send_cmd(OP_TICK, '0, '0, '0, '0);
        send_cmd(OP_CANCEL, 16'hFFFF, '0, '0, '0);
        send_cmd(OP_CANCEL, 16'hFFFF, '0, '0, '0);
        send_cmd(OP_ADD, 16'd100, TIME_MAX - 10, '1, '0);
        send_cmd(OP_TICK, '0, '0, '0, TIME_MAX - 5);
        send_cmd(OP_TICK, '0, '0, '0, TIME_MAX);
        send_cmd(OP_CANCEL, 16'd100, '0, '0, '0);
    endtask

    task automatic test_full_table();
        for (int i = 1; i <= CAPACITY; i++)
            send_cmd(OP_ADD, ID_W'(i), TIME_W'(50 * (CAPACITY + 1 - i)),
                     (i % 2 == 0) ? IV_W'(7) : '0, '0);
        send_cmd(OP_ADD, ID_W'(CAPACITY + 1), 63'd10, '0, '0);
        // duplicate wins over full
        send_cmd(OP_ADD, 16'd3, 63'd10, '0, '0);
        send_cmd(OP_TICK, '0, '0, '0, 63'd1000);
        wall_now = 63'd1000;
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        int sent;
        bit counted;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < count) begin
            send_random_cmd(counted);
            if (counted)
                sent = sent + 1;
        end
    endtask

    task automatic test_long_stall();
        bit counted;
        send_cmd(OP_TICK, '0, '0, '0, wall_now);
        // hold the result side while commands keep coming
        hold_left = HOLD_CYCLES;
        repeat (12)
            send_random_cmd(counted);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_ADD;
        foreach (armed[i]) begin
            armed[i]      = 1'b0;
            arm_id[i]     = '0;
            arm_due[i]    = '0;
            arm_period[i] = '0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 46;
        test_basic_ops();
        test_full_table();
        test_random_traffic(110, 16, 46);
        test_long_stall();
        test_random_traffic(100, 46, 16);
        wait_drained();
        test_random_traffic(110, 0, 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
